FILE: src/assert_macros.svh
// Assertion macros shared by the sweep-and-prune pair emitter RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

FILE: src/spe_pkg.sv
// Shared types and constants for the sweep-and-prune pair emitter.
// No dependencies.
package spe_pkg;

	localparam int IDX_W = 6;
	localparam int GRP_BITS = 8;

	typedef struct packed {
		logic             new_sweep;
		logic             is_end;
		logic             from_object;
		logic [IDX_W-1:0] geom_index;
	} event_t;

	typedef struct packed {
		logic [IDX_W-1:0] pair_first;
		logic [IDX_W-1:0] pair_second;
		logic             last_pair;
	} result_t;

	typedef struct packed {
		logic emit;
		logic last;
	} scan_stat_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

FILE: src/spe_sets.sv
// Active-set bitmaps of both objects and the per-event set update.
// Depends on spe_pkg.
module spe_sets #(
	parameter int MAX_GEOMS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  spe_pkg::event_t       evt,
	output logic [MAX_GEOMS-1:0]  other,
	output logic                  scan
);
	import spe_pkg::*;

	logic [MAX_GEOMS-1:0] first_q, second_q;
	logic [MAX_GEOMS-1:0] base_first, base_second, bit_sel;
	logic [MAX_GEOMS-1:0] first_nxt, second_nxt;
	logic                 in_range;

	always_comb begin
		in_range    = {1'b0, evt.geom_index} < (IDX_W+1)'(MAX_GEOMS);
		base_first  = evt.new_sweep ? '0 : first_q;
		base_second = evt.new_sweep ? '0 : second_q;
		bit_sel     = MAX_GEOMS'(1) << evt.geom_index;
		other       = evt.from_object ? base_first : base_second;
		scan        = accept && in_range && !evt.is_end && (|other);
		first_nxt   = base_first;
		second_nxt  = base_second;
		if (in_range) begin
			if (!evt.from_object) begin
				first_nxt = evt.is_end ? (base_first & ~bit_sel) : (base_first | bit_sel);
			end else begin
				second_nxt = evt.is_end ? (base_second & ~bit_sel) : (base_second | bit_sel);
			end
		end
	end

	// own bit goes in at accept; the scan works from a snapshot of the other set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
		end else if (accept) begin
			first_q  <= first_nxt;
			second_q <= second_nxt;
		end
	end

endmodule

FILE: src/spe_scan.sv
// Shared scan unit: walks a snapshot of the other active set eight bits at a
// time and emits one pair per set bit. Depends on spe_pkg and assert_macros.svh.
`include "assert_macros.svh"
module spe_scan #(
	parameter int MAX_GEOMS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic                   run,
	input  logic [MAX_GEOMS-1:0]   vec,
	input  logic [spe_pkg::IDX_W-1:0] own_idx,
	input  logic                   own_obj,
	output spe_pkg::scan_stat_t    stat,
	output logic                   result_valid,
	output spe_pkg::result_t       result
);
	import spe_pkg::*;

	localparam int NGRP  = (MAX_GEOMS + GRP_BITS - 1) / GRP_BITS;
	localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int NPAD  = 1 << GW;
	localparam int PAD_W = NPAD * GRP_BITS;

	logic [PAD_W-1:0]    wrk_q, wrk_nxt;
	logic [GW-1:0]       grp_q;
	logic [IDX_W-1:0]    own_q;
	logic                obj_q;
	logic [GRP_BITS-1:0] grp_bits, low_oh;
	logic [2:0]          enc;
	logic [IDX_W-1:0]    hit_idx;
	logic                result_valid_q;
	result_t             result_q;

	always_comb begin
		grp_bits = wrk_q[{grp_q, 3'b000} +: GRP_BITS];
		low_oh   = grp_bits & (~grp_bits + 1'b1);
		enc      = '0;
		for (int i = GRP_BITS - 1; i >= 0; i--) begin
			if (grp_bits[i]) begin
				enc = 3'(i);
			end
		end
		hit_idx   = IDX_W'({grp_q, enc});
		wrk_nxt   = wrk_q & ~(PAD_W'(low_oh) << {grp_q, 3'b000});
		stat.emit = run && (|grp_bits);
		stat.last = stat.emit && (wrk_nxt == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrk_q          <= '0;
			grp_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= stat.emit;
			if (load) begin
				wrk_q <= PAD_W'(vec);
				grp_q <= '0;
			end else if (stat.emit) begin
				wrk_q <= wrk_nxt;
			end else if (run) begin
				// empty group: advance
				grp_q <= grp_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			own_q <= own_idx;
			obj_q <= own_obj;
		end
		if (stat.emit) begin
			result_q.pair_first  <= obj_q ? hit_idx : own_q;
			result_q.pair_second <= obj_q ? own_q : hit_idx;
			result_q.last_pair   <= stat.last;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ASSERT_CLK(a_skip_no_beat, (run && !stat.emit) |=> !result_valid, "beat without a hit")
	`ASSERT_NEVER(a_load_in_scan, load && run, "scan reloaded while running")

endmodule

FILE: src/sweep_prune_pair_emitter.sv
// Sweep-and-prune pair emitter. End events, out-of-range indexes and starts
// against an empty other set leave busy low. A start with pairs holds busy
// while the scan unit emits each pair and steps past each 8-bit group below the
// group of its highest pair, and the next beat is taken once busy falls; each pair leaves as
// a one-cycle beat in the cycle after the scan unit finds it. Receiver cannot stall.
// Reset (arst_n low, asynchronous) clears both active sets and goes idle.
`include "assert_macros.svh"
module sweep_prune_pair_emitter #(
	parameter int MAX_GEOMS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  spe_pkg::event_t  evt,
	output logic             result_valid,
	output spe_pkg::result_t result
);
	import spe_pkg::*;

	state_t               state_q, state_nxt;
	logic                 accept, scan;
	logic [MAX_GEOMS-1:0] other;
	scan_stat_t           stat;

	assign busy   = (state_q == ST_SCAN);
	assign accept = start && !busy;

	spe_sets #(.MAX_GEOMS(MAX_GEOMS)) u_sets (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.evt    (evt),
		.other  (other),
		.scan   (scan)
	);

	spe_scan #(.MAX_GEOMS(MAX_GEOMS)) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (scan),
		.run          (busy),
		.vec          (other),
		.own_idx      (evt.geom_index),
		.own_obj      (evt.from_object),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (scan) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	`ASSERT_CLK(a_idle_after_last, $fell(busy) |-> (result_valid && result.last_pair), "no last pair")
	`ASSERT_CLK(a_beat_from_scan, result_valid |-> $past(busy), "beat outside a scan")
	`ASSERT_CLK(a_last_ends_scan, (result_valid && result.last_pair) |-> !busy, "scan past last pair")

endmodule
